// ===== rtl/countdown_timer_bank_assert.svh =====
// Assertion macros for the port-level checker of the countdown timer bank.
`ifndef COUNTDOWN_TIMER_BANK_ASSERT_SVH
`define COUNTDOWN_TIMER_BANK_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CTB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CTB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ctb_pkg.sv =====
// Types, constants and codes shared by the countdown timer bank modules.
package ctb_pkg;

   localparam int NUM_SLOTS   = 32;
   localparam int SLOT_AW     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int WALK_W      = SLOT_AW + 1;
   localparam int STEP_W      = 23;
   // The queue depth must stay a power of two so the pointers wrap on their own.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [31:0] USEC_PER_MSEC = 32'd1000;
   // floor(x / 1000) == (x * RECIP) >> RECIP_SHIFT for every 32-bit x.
   localparam logic [31:0] RECIP       = 32'd274877907;
   localparam int          RECIP_SHIFT = 38;
   localparam logic [STEP_W-1:0] MAX_STEP = 23'd4294967;

   localparam logic [2:0] OP_TICK       = 3'd0;
   localparam logic [2:0] OP_WRITE      = 3'd1;
   localparam logic [2:0] OP_ACTIVATE   = 3'd2;
   localparam logic [2:0] OP_DEACTIVATE = 3'd3;
   localparam logic [2:0] OP_READ       = 3'd4;
   localparam logic [2:0] OP_MAX_CLEAR  = 3'd5;

   typedef enum logic [2:0] {
      KIND_TICK,
      KIND_WRITE,
      KIND_ACTIVATE,
      KIND_DEACTIVATE,
      KIND_READ,
      KIND_MAX_CLEAR,
      KIND_NONE
   } ctb_kind_type;

   typedef struct packed {
      logic [2:0]         operation;
      logic [4:0]         slot;
      logic signed [31:0] write_value;
      logic [31:0]        counter_sample;
   } ctb_req_type;

   typedef struct packed {
      logic signed [31:0] timer_value;
      logic               slot_active;
      logic [31:0]        total_ms;
      logic [STEP_W-1:0]  max_step_ms;
   } ctb_rsp_type;

   typedef struct packed {
      ctb_kind_type       kind;
      logic [SLOT_AW-1:0] slot;
      logic [31:0]        data;
   } ctb_cmd_type;

endpackage

// ===== rtl/countdown_timer_bank.sv =====
// Top level of the countdown timer bank: front end, command queue and execution engine.
//
// A word is taken on a rising edge with start high and busy low; busy rises only
// while the two-entry command queue is full. Every word gives exactly one result,
// shown on rsp_word for one cycle with rsp_strobe high, and the receiver has no
// way to hold it off. Write, read-clear and unused operations answer from the idle
// state, read, activate and deactivate after the slot read state, and a tick under
// a millisecond after the multiply and divide states. A tick that moves the timers
// walks one slot per cycle, reading and writing back through the single slot
// memory, after a reciprocal multiply that turns the microsecond delta into whole
// milliseconds. Results come back in the order the words were taken.
module countdown_timer_bank import ctb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  ctb_req_type req_word,
   output logic        rsp_strobe,
   output ctb_rsp_type rsp_word
);
   logic        push;
   logic        pop;
   logic        queue_empty;
   logic        queue_full;
   ctb_cmd_type front_cmd;
   ctb_cmd_type head_cmd;

   ctb_front u_front (
      .start     (start),
      .req_word  (req_word),
      .queue_full(queue_full),
      .busy      (busy),
      .push      (push),
      .cmd       (front_cmd)
   );

   ctb_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_cmd(front_cmd),
      .pop     (pop),
      .head    (head_cmd),
      .empty   (queue_empty),
      .full    (queue_full)
   );

   ctb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head_cmd),
      .queue_empty(queue_empty),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

// ===== rtl/ctb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ctb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ctb_front.sv =====
// Front end: takes request words and classifies them into commands for the queue.
module ctb_front import ctb_pkg::*; (
   input  logic        start,
   input  ctb_req_type req_word,
   input  logic        queue_full,
   output logic        busy,
   output logic        push,
   output ctb_cmd_type cmd
);
   logic in_range;

   assign in_range = ({4'b0, req_word.slot} < 9'(NUM_SLOTS));
   assign busy     = queue_full;
   assign push     = start & ~queue_full;

   always_comb begin
      cmd.slot = SLOT_AW'(req_word.slot);
      cmd.data = req_word.write_value;
      unique case (req_word.operation)
         OP_TICK: begin
            cmd.kind = KIND_TICK;
            cmd.data = req_word.counter_sample;
         end
         OP_WRITE:      cmd.kind = in_range ? KIND_WRITE      : KIND_NONE;
         OP_ACTIVATE:   cmd.kind = in_range ? KIND_ACTIVATE   : KIND_NONE;
         OP_DEACTIVATE: cmd.kind = in_range ? KIND_DEACTIVATE : KIND_NONE;
         OP_READ:       cmd.kind = in_range ? KIND_READ       : KIND_NONE;
         OP_MAX_CLEAR:  cmd.kind = KIND_MAX_CLEAR;
         default:       cmd.kind = KIND_NONE;
      endcase
   end

endmodule

// ===== rtl/ctb_queue.sv =====
// Short command queue between the front end and the execution engine.
module ctb_queue import ctb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  ctb_cmd_type push_cmd,
   input  logic        pop,
   output ctb_cmd_type head,
   output logic        empty,
   output logic        full
);
   ctb_cmd_type         entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0] count_ff, count_in;
   logic                do_pop;

   assign empty  = (count_ff == '0);
   assign full   = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign head   = entry_ff[rd_ptr_ff];
   assign do_pop = pop & ~empty;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CW'(push) - QUEUE_CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/ctb_back.sv =====
// Execution engine: runs slot commands and the tick walk over the slot memory.
module ctb_back import ctb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  ctb_cmd_type head,
   input  logic        queue_empty,
   output logic        pop,
   output logic        rsp_strobe,
   output ctb_rsp_type rsp_word
);
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SLOT_RD,
      ST_MUL,
      ST_DIV,
      ST_REM,
      ST_WALK,
      ST_TICK_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [SLOT_AW-1:0] slot_ff, slot_in;
   logic [31:0]        delta_ff, delta_in;
   logic [63:0]        prod_ff, prod_in;
   logic [STEP_W-1:0]  ms_ff, ms_in;
   logic [31:0]        step_us_ff, step_us_in;
   logic [31:0]        prev_ff, prev_in;
   logic [31:0]        elapsed_ff, elapsed_in;
   logic [STEP_W-1:0]  largest_ff, largest_in;
   logic [NUM_SLOTS-1:0] mask_ff, mask_in;
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [WALK_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic               wb_pend_ff, wb_pend_in;
   logic [SLOT_AW-1:0] wb_idx_ff, wb_idx_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   ctb_rsp_type        rsp_ff, rsp_in;

   logic               ram_wr_en;
   logic [SLOT_AW-1:0] ram_wr_addr;
   logic [31:0]        ram_wr_data;
   logic               ram_rd_en;
   logic [SLOT_AW-1:0] ram_rd_addr;
   logic [31:0]        ram_rd_data;
   logic signed [31:0] cur_value;
   logic signed [31:0] ms_signed;

   ctb_ram #(
      .WIDTH(32),
      .DEPTH(NUM_SLOTS)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign cur_value = $signed(ram_rd_data);
   assign ms_signed = $signed({9'b0, ms_ff});

   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      delta_in      = delta_ff;
      prod_in       = prod_ff;
      ms_in         = ms_ff;
      step_us_in    = step_us_ff;
      prev_in       = prev_ff;
      elapsed_in    = elapsed_ff;
      largest_in    = largest_ff;
      mask_in       = mask_ff;
      valid_in      = valid_ff;
      rd_cnt_in     = rd_cnt_ff;
      wb_pend_in    = wb_pend_ff;
      wb_idx_in     = wb_idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      pop           = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = head.slot;
      ram_wr_data   = head.data;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = head.slot;

      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               pop                 = 1'b1;
               slot_in             = head.slot;
               rsp_in.timer_value  = '0;
               rsp_in.slot_active  = 1'b0;
               rsp_in.total_ms     = elapsed_ff;
               rsp_in.max_step_ms  = largest_ff;
               unique case (head.kind)
                  KIND_TICK: begin
                     delta_in = head.data - prev_ff;
                     state_in = ST_MUL;
                  end
                  KIND_WRITE: begin
                     ram_wr_en          = 1'b1;
                     valid_in[head.slot] = 1'b1;
                     rsp_in.timer_value = $signed(head.data);
                     rsp_in.slot_active = mask_ff[head.slot];
                     rsp_strobe_in      = 1'b1;
                  end
                  KIND_ACTIVATE: begin
                     mask_in[head.slot] = 1'b1;
                     ram_rd_en          = 1'b1;
                     state_in           = ST_SLOT_RD;
                  end
                  KIND_DEACTIVATE: begin
                     mask_in[head.slot] = 1'b0;
                     ram_rd_en          = 1'b1;
                     state_in           = ST_SLOT_RD;
                  end
                  KIND_READ: begin
                     ram_rd_en = 1'b1;
                     state_in  = ST_SLOT_RD;
                  end
                  KIND_MAX_CLEAR: begin
                     largest_in    = '0;
                     rsp_strobe_in = 1'b1;
                  end
                  KIND_NONE: begin
                     rsp_strobe_in = 1'b1;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end

         ST_SLOT_RD: begin
            rsp_in.timer_value = rd_valid_ff ? cur_value : '0;
            rsp_in.slot_active = mask_ff[slot_ff];
            rsp_strobe_in      = 1'b1;
            state_in           = ST_IDLE;
         end

         ST_MUL: begin
            prod_in  = {32'b0, delta_ff} * {32'b0, RECIP};
            state_in = ST_DIV;
         end

         ST_DIV: begin
            ms_in = prod_ff[RECIP_SHIFT +: STEP_W];
            if (delta_ff < USEC_PER_MSEC) begin
               // Less than a whole millisecond: nothing moves.
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_REM;
            end
         end

         ST_REM: begin
            // The carried sample is the old one plus the whole milliseconds used.
            step_us_in = {9'b0, ms_ff} * USEC_PER_MSEC;
            rd_cnt_in  = '0;
            wb_pend_in = 1'b0;
            state_in   = ST_WALK;
         end

         ST_WALK: begin
            // Reads run one slot ahead of the write-back of the previous slot.
            if (rd_cnt_ff < WALK_W'(NUM_SLOTS)) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = rd_cnt_ff[SLOT_AW-1:0];
               rd_cnt_in   = rd_cnt_ff + 1'b1;
               wb_pend_in  = 1'b1;
               wb_idx_in   = rd_cnt_ff[SLOT_AW-1:0];
            end else begin
               wb_pend_in = 1'b0;
               state_in   = ST_TICK_DONE;
            end
            ram_wr_addr = wb_idx_ff;
            if (wb_pend_ff && rd_valid_ff && mask_ff[wb_idx_ff]) begin
               if (cur_value > ms_signed) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = cur_value - ms_signed;
               end else if (cur_value > 32'sd0) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = '0;
               end
            end
         end

         ST_TICK_DONE: begin
            prev_in            = prev_ff + step_us_ff;
            elapsed_in         = elapsed_ff + {9'b0, ms_ff};
            largest_in         = (ms_ff > largest_ff) ? ms_ff : largest_ff;
            rsp_in.timer_value = '0;
            rsp_in.slot_active = 1'b0;
            rsp_in.total_ms    = elapsed_in;
            rsp_in.max_step_ms = largest_in;
            rsp_strobe_in      = 1'b1;
            state_in           = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rd_valid_in = ram_rd_en ? valid_ff[ram_rd_addr] : rd_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         prev_ff       <= '0;
         elapsed_ff    <= '0;
         largest_ff    <= '0;
         mask_ff       <= '0;
         valid_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         rd_cnt_ff     <= '0;
         wb_pend_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prev_ff       <= prev_in;
         elapsed_ff    <= elapsed_in;
         largest_ff    <= largest_in;
         mask_ff       <= mask_in;
         valid_ff      <= valid_in;
         rd_valid_ff   <= rd_valid_in;
         rd_cnt_ff     <= rd_cnt_in;
         wb_pend_ff    <= wb_pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      slot_ff    <= slot_in;
      delta_ff   <= delta_in;
      prod_ff    <= prod_in;
      ms_ff      <= ms_in;
      step_us_ff <= step_us_in;
      wb_idx_ff  <= wb_idx_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

// ===== rtl/ctb_checker.sv =====
// Port-level checker for the countdown timer bank, bound to the top level.
`include "countdown_timer_bank_assert.svh"

module ctb_checker import ctb_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input ctb_req_type req_word,
   input logic        rsp_strobe,
   input ctb_rsp_type rsp_word
);
   logic [2:0] pending_ff, pending_in;
   logic       accept;

   assign accept = start & ~busy;

   // Words taken and not yet answered.
   always_comb begin
      pending_in = pending_ff + 3'(accept) - 3'(rsp_strobe);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `CTB_ASSERT_NOW(a_no_spurious_result, clock, reset, rsp_strobe, pending_ff != 3'd0, "result without a pending word")
   `CTB_ASSERT_NOW(a_idle_not_busy, clock, reset, pending_ff == 3'd0, !busy, "busy with no pending word")
   `CTB_ASSERT_NOW(a_step_in_range, clock, reset, rsp_strobe, rsp_word.max_step_ms <= MAX_STEP, "max step out of range")
   `CTB_ASSERT_NEXT(a_first_word_not_busy, clock, reset, accept && (pending_ff == 3'd0), !busy, "busy after a single word")

endmodule

bind countdown_timer_bank ctb_checker u_ctb_checker (.*);

// ===== bench/countdown_timer_bank_checker.sv =====
`timescale 1ns / 1ps
// Checker for the countdown timer bank: predicts each result and compares what comes back.
module countdown_timer_bank_checker import ctb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  ctb_req_type req_word,
   input  logic        rsp_strobe,
   input  ctb_rsp_type rsp_word,
   output int          outstanding,
   output int          mismatches,
   output int          results_checked
);

   // Shadow copy of the timer bank.
   logic signed [31:0]   slot_count [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] armed;
   logic [31:0]          last_sample;
   logic [31:0]          elapsed_total;
   logic [STEP_W-1:0]    peak_step;

   ctb_rsp_type pending_results [$];
   int          bad_count = 0;
   int          seen_count = 0;

   assign mismatches      = bad_count;
   assign results_checked = seen_count;

   function automatic ctb_rsp_type predict_result(ctb_req_type w);
      ctb_rsp_type r;
      logic [31:0] delta;
      logic [31:0] ms;
      logic [31:0] rem;
      longint      held;
      r = '0;
      if (w.operation == OP_TICK) begin
         delta = w.counter_sample - last_sample;
         if (delta >= USEC_PER_MSEC) begin
            ms  = delta / USEC_PER_MSEC;
            rem = delta % USEC_PER_MSEC;
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (armed[i]) begin
                  held = slot_count[i];
                  // Positive slots clamp at zero; zero and negative slots are left alone.
                  if (held > longint'(ms))
                     slot_count[i] = 32'(held - longint'(ms));
                  else if (held > 0)
                     slot_count[i] = '0;
               end
            end
            last_sample   = w.counter_sample - rem;
            elapsed_total = elapsed_total + ms;
            if (ms > 32'(peak_step))
               peak_step = ms[STEP_W-1:0];
         end
      end else if (w.operation == OP_WRITE || w.operation == OP_ACTIVATE ||
                   w.operation == OP_DEACTIVATE || w.operation == OP_READ) begin
         if (w.slot < NUM_SLOTS) begin
            if (w.operation == OP_WRITE)
               slot_count[w.slot] = w.write_value;
            else if (w.operation == OP_ACTIVATE)
               armed[w.slot] = 1'b1;
            else if (w.operation == OP_DEACTIVATE)
               armed[w.slot] = 1'b0;
            r.timer_value = slot_count[w.slot];
            r.slot_active = armed[w.slot];
         end
      end
      r.total_ms    = elapsed_total;
      r.max_step_ms = peak_step;
      if (w.operation == OP_MAX_CLEAR)
         peak_step = '0;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      ctb_rsp_type want;
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++)
            slot_count[i] = '0;
         armed         = '0;
         last_sample   = '0;
         elapsed_total = '0;
         peak_step     = '0;
         pending_results.delete();
      end else begin
         // A result never comes back on the edge that accepts its word, so the compare goes first.
         if (rsp_strobe) begin
            seen_count = seen_count + 1;
            if (pending_results.size() == 0) begin
               if (bad_count < 10)
                  $display("%0t: result with nothing expected: value %0d active %0b total %0d max %0d",
                           $realtime, rsp_word.timer_value, rsp_word.slot_active,
                           rsp_word.total_ms, rsp_word.max_step_ms);
               bad_count = bad_count + 1;
            end else begin
               want = pending_results.pop_front();
               if (rsp_word.timer_value !== want.timer_value ||
                   rsp_word.slot_active !== want.slot_active ||
                   rsp_word.total_ms !== want.total_ms ||
                   rsp_word.max_step_ms !== want.max_step_ms) begin
                  if (bad_count < 10) begin
                     $display("%0t: wrong result", $realtime);
                     $display("   expected value %0d active %0b total %0d max %0d",
                              want.timer_value, want.slot_active, want.total_ms,
                              want.max_step_ms);
                     $display("   actual   value %0d active %0b total %0d max %0d",
                              rsp_word.timer_value, rsp_word.slot_active,
                              rsp_word.total_ms, rsp_word.max_step_ms);
                  end
                  bad_count = bad_count + 1;
               end
            end
         end
         if (start && !busy)
            pending_results.push_back(predict_result(req_word));
      end
      outstanding <= pending_results.size();
   end

endmodule

// ===== bench/countdown_timer_bank_tb.sv =====
`timescale 1ns / 1ps
// Top of the countdown timer bank testbench: clock, reset, stimulus and verdict.
module countdown_timer_bank_tb;
   import ctb_pkg::*;

   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam int RANDOM_WORDS  = 1250;
   localparam int SETTLE_CYCLES = NUM_SLOTS + 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   ctb_req_type req_word = '0;
   logic        rsp_strobe;
   ctb_rsp_type rsp_word;

   int outstanding;
   int mismatches;
   int results_checked;

   int          words_by_op [8];
   int          words_sent = 0;
   logic [31:0] now_us = '0;   // last counter sample handed to the block
   bit          no_idle = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   countdown_timer_bank dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   countdown_timer_bank_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_word        (req_word),
      .rsp_strobe      (rsp_strobe),
      .rsp_word        (rsp_word),
      .outstanding     (outstanding),
      .mismatches      (mismatches),
      .results_checked (results_checked)
   );

   function automatic ctb_req_type word_of(logic [2:0] op, logic [4:0] slot,
                                           logic [31:0] value, logic [31:0] sample);
      ctb_req_type w;
      w.operation      = op;
      w.slot           = slot;
      w.write_value    = value;
      w.counter_sample = sample;
      return w;
   endfunction

   // Mostly plausible counter progress and small timer values, so slots count down to zero.
   function automatic ctb_req_type random_word();
      ctb_req_type w;
      int          pick;
      int          sub;
      w = word_of(OP_READ, 5'($urandom), $urandom, $urandom);
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         w.operation = OP_TICK;
         sub = $urandom_range(0, 9);
         if (sub < 2)
            now_us = now_us + $urandom_range(0, 999);
         else if (sub < 7)
            now_us = now_us + $urandom_range(1000, 4999);
         else if (sub < 9)
            now_us = now_us + $urandom_range(5000, 200000);
         else
            now_us = now_us + $urandom;
         w.counter_sample = now_us;
      end else if (pick < 55) begin
         w.operation = OP_WRITE;
         sub = $urandom_range(0, 9);
         if (sub < 6)
            w.write_value = $urandom_range(0, 40);
         else if (sub < 8)
            w.write_value = -$urandom_range(1, 40);
         else if (sub < 9)
            w.write_value = $urandom;
         else
            w.write_value = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end else if (pick < 70) begin
         w.operation = OP_ACTIVATE;
      end else if (pick < 78) begin
         w.operation = OP_DEACTIVATE;
      end else if (pick < 92) begin
         w.operation = OP_READ;
      end else if (pick < 97) begin
         w.operation = OP_MAX_CLEAR;
      end else if (pick < 99) begin
         // A tick with an arbitrary sample, as after a counter glitch.
         w.operation = OP_TICK;
         now_us      = w.counter_sample;
      end else begin
         w.operation = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
      end
      return w;
   endfunction

   task automatic send_word(input ctb_req_type w);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 9);
      req_word <= w;
      start    <= 1'b1;
      words_by_op[w.operation] += 1;
      words_sent++;
      do @(posedge clock); while (busy);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: extremes, every operation, clamping, wrap and the largest step.
      send_word(word_of(OP_MAX_CLEAR, 5'd0, $urandom, $urandom));
      send_word(word_of(OP_READ, 5'd0, $urandom, $urandom));
      send_word(word_of(OP_WRITE, 5'd0, 32'h7FFF_FFFF, $urandom));
      send_word(word_of(OP_WRITE, 5'd31, 32'h8000_0000, $urandom));
      send_word(word_of(OP_WRITE, 5'd1, 32'd5, $urandom));
      send_word(word_of(OP_WRITE, 5'd2, -32'sd3, $urandom));
      send_word(word_of(OP_WRITE, 5'd3, 32'd0, $urandom));
      send_word(word_of(OP_ACTIVATE, 5'd0, $urandom, $urandom));
      send_word(word_of(OP_ACTIVATE, 5'd1, $urandom, $urandom));
      send_word(word_of(OP_ACTIVATE, 5'd2, $urandom, $urandom));
      send_word(word_of(OP_ACTIVATE, 5'd3, $urandom, $urandom));
      send_word(word_of(OP_ACTIVATE, 5'd31, $urandom, $urandom));
      send_word(word_of(OP_ACTIVATE, 5'd1, $urandom, $urandom));
      send_word(word_of(OP_TICK, 5'($urandom), $urandom, 32'd999));
      send_word(word_of(OP_TICK, 5'($urandom), $urandom, 32'd1000));
      // One below the previous sample: the full 32-bit delta, the largest possible step.
      send_word(word_of(OP_TICK, 5'($urandom), $urandom, 32'd999));
      send_word(word_of(OP_MAX_CLEAR, 5'($urandom), $urandom, $urandom));
      send_word(word_of(OP_MAX_CLEAR, 5'($urandom), $urandom, $urandom));
      send_word(word_of(OP_DEACTIVATE, 5'd0, $urandom, $urandom));
      send_word(word_of(OP_DEACTIVATE, 5'd0, $urandom, $urandom));
      send_word(word_of(OP_WRITE, 5'd0, 32'h0000_1234, $urandom));
      send_word(word_of(OP_READ, 5'd0, $urandom, $urandom));
      send_word(word_of(OP_SPARE_LO, 5'($urandom), $urandom, $urandom));
      send_word(word_of(OP_SPARE_HI, 5'($urandom), $urandom, $urandom));
      send_word(word_of(OP_READ, 5'd31, $urandom, $urandom));
      now_us = 32'd999;
      drain();

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 64 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_WORDS / 2)
            drain();
         send_word(random_word());
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d words: %0d ticks, %0d writes, %0d activates, %0d deactivates,",
               words_sent, words_by_op[OP_TICK], words_by_op[OP_WRITE],
               words_by_op[OP_ACTIVATE], words_by_op[OP_DEACTIVATE]);
      $display("%0d reads, %0d max-step clears, %0d spare codes; %0d results compared.",
               words_by_op[OP_READ], words_by_op[OP_MAX_CLEAR],
               words_by_op[OP_SPARE_LO] + words_by_op[OP_SPARE_HI], results_checked);
      if (mismatches == 0 && outstanding == 0)
         $display("countdown_timer_bank: match");
      else
         $display("countdown_timer_bank: mismatch");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d results still expected.", outstanding);
      $display("countdown_timer_bank: mismatch");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ctb_pkg.sv
rtl/ctb_ram.sv
rtl/ctb_front.sv
rtl/ctb_queue.sv
rtl/ctb_back.sv
rtl/countdown_timer_bank.sv
rtl/ctb_checker.sv
bench/countdown_timer_bank_checker.sv
bench/countdown_timer_bank_tb.sv
